// ----- hdl/hsc_pkg.sv -----
package hsc_pkg;

   localparam int TIME_BITS_DEF = 32;
   localparam int NOW_W         = 32;
   localparam int GAP_W         = 16;
   localparam int CSR_INDEX_W   = 3;

   // Link states, one-hot; link_num() gives the external numbering.
   typedef enum logic [17:0] {
      LS_UNUSED       = 18'h00001,
      LS_CONNECTING   = 18'h00002,
      LS_CONNECTED    = 18'h00004,
      LS_MAPINFO      = 18'h00008,
      LS_BADMAP       = 18'h00010,
      LS_SYNCED       = 18'h00020,
      LS_ASYNC        = 18'h00040,
      LS_CHANGED      = 18'h00080,
      LS_DETACHING    = 18'h00100,
      LS_DISCONNECTED = 18'h00200,
      LS_UNREACHABLE  = 18'h00400,
      LS_USERCANCELED = 18'h00800,
      LS_NOFREESLOTS  = 18'h01000,
      LS_SERVERQUITS  = 18'h02000,
      LS_GOAHEAD      = 18'h04000,
      LS_STARTED      = 18'h08000,
      LS_BADENGINE    = 18'h10000,
      LS_BADNETWORK   = 18'h20000
   } link_state_type;

   // Message kinds sent
   localparam logic [3:0] SK_NONE     = 4'd0;
   localparam logic [3:0] SK_HELLO    = 4'd1;
   localparam logic [3:0] SK_WAITING  = 4'd2;
   localparam logic [3:0] SK_MAP      = 4'd3;
   localparam logic [3:0] SK_MISMATCH = 4'd4;
   localparam logic [3:0] SK_STATE    = 4'd5;
   localparam logic [3:0] SK_RESYNC   = 4'd6;
   localparam logic [3:0] SK_CONFIG   = 4'd7;
   localparam logic [3:0] SK_GO       = 4'd8;
   localparam logic [3:0] SK_GOODBYE  = 4'd9;
   localparam logic [3:0] SK_SEEYOU   = 4'd10;
   localparam logic [3:0] SK_IAMHERE  = 4'd11;

   // Message kinds received
   localparam logic [3:0] RX_QUIT     = 4'd0;
   localparam logic [3:0] RX_AYT      = 4'd1;
   localparam logic [3:0] RX_GOODBYE  = 4'd2;
   localparam logic [3:0] RX_ENGINE   = 4'd3;
   localparam logic [3:0] RX_PROTOCOL = 4'd4;
   localparam logic [3:0] RX_FULL     = 4'd5;
   localparam logic [3:0] RX_WELCOME  = 4'd6;
   localparam logic [3:0] RX_MAP      = 4'd7;
   localparam logic [3:0] RX_STATE    = 4'd8;
   localparam logic [3:0] RX_CONFIG   = 4'd9;
   localparam logic [3:0] RX_RESYNC   = 4'd10;
   localparam logic [3:0] RX_GO       = 4'd11;

   // Item operations
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_RX     = 2'd1;
   localparam logic [1:0] OP_DETACH = 2'd2;
   localparam logic [1:0] OP_INIT   = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HELLO_GAP     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GOODBYE_GAP   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAIT_CONN_GAP = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAIT_SYNC_GAP = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_GAP       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATE_GAP     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_GAP     = 3'd6;

   // Register reset values
   localparam logic [GAP_W-1:0] HELLO_GAP_RST     = 16'd500;
   localparam logic [GAP_W-1:0] GOODBYE_GAP_RST   = 16'd100;
   localparam logic [GAP_W-1:0] WAIT_CONN_GAP_RST = 16'd650;
   localparam logic [GAP_W-1:0] WAIT_SYNC_GAP_RST = 16'd850;
   localparam logic [GAP_W-1:0] MAP_GAP_RST       = 16'd650;
   localparam logic [GAP_W-1:0] STATE_GAP_RST     = 16'd450;
   localparam logic [GAP_W-1:0] START_GAP_RST     = 16'd250;

   // Retry budgets
   localparam logic [7:0] BUDGET_HELLO   = 8'd48;
   localparam logic [7:0] BUDGET_WAIT    = 8'd20;
   localparam logic [7:0] BUDGET_GOODBYE = 8'd10;
   localparam logic [7:0] BUDGET_CONFIG  = 8'd50;
   localparam logic [7:0] RETRY_MAX      = 8'hFF;

   localparam int FAREWELL_BURST = 5;
   localparam int BURST_CNT_W    = $clog2(FAREWELL_BURST);

   typedef struct packed {
      logic [GAP_W-1:0] hello;
      logic [GAP_W-1:0] goodbye;
      logic [GAP_W-1:0] wait_conn;
      logic [GAP_W-1:0] wait_sync;
      logic [GAP_W-1:0] map;
      logic [GAP_W-1:0] state;
      logic [GAP_W-1:0] start;
   } gaps_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [NOW_W-1:0] now_ms;
      logic [3:0]       rx_kind;
      logic             from_server;
      logic             map_matches;
      logic             setup_in_sync;
   } item_type;

   typedef struct packed {
      logic [3:0] send_kind;
      logic       keep_going;
      logic [4:0] link_state_out;
   } rsp_type;

   typedef struct packed {
      rsp_type rsp;
      logic    burst;
   } step_ctl_type;

   function automatic logic [4:0] link_num(link_state_type s);
      logic [4:0] n;
      case (s)
         LS_UNUSED:       n = 5'd0;
         LS_CONNECTING:   n = 5'd1;
         LS_CONNECTED:    n = 5'd2;
         LS_MAPINFO:      n = 5'd3;
         LS_BADMAP:       n = 5'd4;
         LS_SYNCED:       n = 5'd5;
         LS_ASYNC:        n = 5'd6;
         LS_CHANGED:      n = 5'd7;
         LS_DETACHING:    n = 5'd8;
         LS_DISCONNECTED: n = 5'd9;
         LS_UNREACHABLE:  n = 5'd10;
         LS_USERCANCELED: n = 5'd11;
         LS_NOFREESLOTS:  n = 5'd12;
         LS_SERVERQUITS:  n = 5'd13;
         LS_GOAHEAD:      n = 5'd14;
         LS_STARTED:      n = 5'd15;
         LS_BADENGINE:    n = 5'd16;
         LS_BADNETWORK:   n = 5'd17;
         default:         n = 5'd0;
      endcase
      return n;
   endfunction

endpackage

// ----- hdl/session_handshake_client_fsm.sv -----
// An accepted item reaches its first result through the input register,
// then the result register; a tick in disconnected gives a farewell burst.
// Throughput: one item per cycle while rsp_ready holds; a farewell burst
// repeats its result FAREWELL_BURST times, and the input side stalls behind it.
// Reset (synchronous): link state unused, counters and send time zero, gap
// registers to their defaults, both channels empty.
module session_handshake_client_fsm #(
   parameter int TIME_BITS = hsc_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // item input
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_op,
   input  logic [hsc_pkg::NOW_W-1:0]       req_now_ms,
   input  logic [3:0]                      req_rx_kind,
   input  logic                            req_from_server,
   input  logic                            req_map_matches,
   input  logic                            req_setup_in_sync,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [3:0]                      rsp_send_kind,
   output logic                            rsp_keep_going,
   output logic [4:0]                      rsp_link_state_out,
   output logic                            rsp_last,
   // register writes
   input  logic                            csr_we,
   input  logic [hsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hsc_pkg::GAP_W-1:0]       csr_wdata
);

   // Input register
   logic                    in_vld_ff, in_vld_in;
   hsc_pkg::item_type       item_ff, item_in;

   // Session state
   hsc_pkg::link_state_type link_state_ff, link_state_in;
   logic [7:0]              retry_ff, retry_in;
   logic [TIME_BITS-1:0]    last_time_ff, last_time_in;
   logic [3:0]              last_kind_ff, last_kind_in;

   // Gap registers
   hsc_pkg::gaps_type       gaps_ff, gaps_in;

   hsc_pkg::step_ctl_type   step_ctl;
   hsc_pkg::rsp_type        rsp;
   logic                    out_free;
   logic                    adv;
   logic                    req_take;

   // Advance the item in the input register whenever the result register
   // can take it; session state moves on that same edge.
   assign adv       = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || out_free;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      item_in   = item_ff;
      if (adv) begin
         in_vld_in = 1'b0;
      end
      if (req_take) begin
         in_vld_in           = 1'b1;
         item_in.op            = req_op;
         item_in.now_ms        = req_now_ms;
         item_in.rx_kind       = req_rx_kind;
         item_in.from_server   = req_from_server;
         item_in.map_matches   = req_map_matches;
         item_in.setup_in_sync = req_setup_in_sync;
      end
   end

   hsc_step #(
      .TIME_BITS(TIME_BITS)
   ) u_step (
      .item           (item_ff),
      .gaps           (gaps_ff),
      .link_state     (link_state_ff),
      .retry_count    (retry_ff),
      .last_time      (last_time_ff),
      .last_kind      (last_kind_ff),
      .nxt_link_state (link_state_in),
      .nxt_retry_count(retry_in),
      .nxt_last_time  (last_time_in),
      .nxt_last_kind  (last_kind_in),
      .ctl            (step_ctl)
   );

   hsc_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (adv),
      .ctl      (step_ctl),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp      (rsp),
      .rsp_last (rsp_last),
      .free     (out_free)
   );

   assign rsp_send_kind      = rsp.send_kind;
   assign rsp_keep_going     = rsp.keep_going;
   assign rsp_link_state_out = rsp.link_state_out;

   // Register writes; an index past the list is dropped
   always_comb begin
      gaps_in = gaps_ff;
      if (csr_we) begin
         case (csr_index)
            hsc_pkg::CSR_HELLO_GAP:     gaps_in.hello     = csr_wdata;
            hsc_pkg::CSR_GOODBYE_GAP:   gaps_in.goodbye   = csr_wdata;
            hsc_pkg::CSR_WAIT_CONN_GAP: gaps_in.wait_conn = csr_wdata;
            hsc_pkg::CSR_WAIT_SYNC_GAP: gaps_in.wait_sync = csr_wdata;
            hsc_pkg::CSR_MAP_GAP:       gaps_in.map       = csr_wdata;
            hsc_pkg::CSR_STATE_GAP:     gaps_in.state     = csr_wdata;
            hsc_pkg::CSR_START_GAP:     gaps_in.start     = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff         <= 1'b0;
         link_state_ff     <= hsc_pkg::LS_UNUSED;
         retry_ff          <= '0;
         last_time_ff      <= '0;
         last_kind_ff      <= hsc_pkg::SK_NONE;
         gaps_ff.hello     <= hsc_pkg::HELLO_GAP_RST;
         gaps_ff.goodbye   <= hsc_pkg::GOODBYE_GAP_RST;
         gaps_ff.wait_conn <= hsc_pkg::WAIT_CONN_GAP_RST;
         gaps_ff.wait_sync <= hsc_pkg::WAIT_SYNC_GAP_RST;
         gaps_ff.map       <= hsc_pkg::MAP_GAP_RST;
         gaps_ff.state     <= hsc_pkg::STATE_GAP_RST;
         gaps_ff.start     <= hsc_pkg::START_GAP_RST;
      end else begin
         in_vld_ff <= in_vld_in;
         gaps_ff   <= gaps_in;
         if (adv) begin
            link_state_ff <= link_state_in;
            retry_ff      <= retry_in;
            last_time_ff  <= last_time_in;
            last_kind_ff  <= last_kind_in;
         end
      end
   end

   // Payload register, no reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // An item that leaves the input register shows up as a result next cycle
   a_adv_to_rsp: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_valid)
      else $error("advanced item did not reach the result register");

   // A burst is never cut short
   a_burst_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("result burst dropped before its last item");

   // Only farewells come in bursts, and they end the session
   a_burst_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |->
         (rsp_send_kind == hsc_pkg::SK_SEEYOU && !rsp_keep_going))
      else $error("non-final result is not a farewell");

   // The input register does not advance while the result side is full
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !adv)
      else $error("item advanced into a stalled result register");

endmodule

// ----- hdl/hsc_step.sv -----
module hsc_step #(
   parameter int TIME_BITS = hsc_pkg::TIME_BITS_DEF
) (
   input  hsc_pkg::item_type       item,
   input  hsc_pkg::gaps_type       gaps,
   input  hsc_pkg::link_state_type link_state,
   input  logic [7:0]              retry_count,
   input  logic [TIME_BITS-1:0]    last_time,
   input  logic [3:0]              last_kind,
   output hsc_pkg::link_state_type nxt_link_state,
   output logic [7:0]              nxt_retry_count,
   output logic [TIME_BITS-1:0]    nxt_last_time,
   output logic [3:0]              nxt_last_kind,
   output hsc_pkg::step_ctl_type   ctl
);

   logic                          tick_active;
   logic                          has_budget;
   logic                          to_unreach;
   logic [3:0]                    tick_kind;
   logic [hsc_pkg::GAP_W-1:0]     tick_gap;
   logic [7:0]                    tick_budget;
   logic [7:0]                    base_retry;
   hsc_pkg::link_state_type       base_state;
   logic [TIME_BITS-1:0]          now_t;
   logic [TIME_BITS-1:0]          elapsed;
   logic                          gap_ok;
   logic [3:0]                    kind;
   logic                          keep;

   assign now_t   = TIME_BITS'(item.now_ms);
   assign elapsed = now_t - last_time;
   assign gap_ok  = elapsed >= TIME_BITS'(tick_gap);

   // Decode what a tick resends in the current state
   always_comb begin
      tick_active = 1'b0;
      has_budget  = 1'b0;
      to_unreach  = 1'b0;
      tick_kind   = hsc_pkg::SK_NONE;
      tick_gap    = '0;
      tick_budget = hsc_pkg::RETRY_MAX;
      base_retry  = retry_count;
      base_state  = link_state;
      case (link_state)
         hsc_pkg::LS_DETACHING: begin
            tick_active = 1'b1; has_budget = 1'b1; to_unreach = 1'b1;
            tick_kind = hsc_pkg::SK_GOODBYE; tick_gap = gaps.goodbye;
            tick_budget = hsc_pkg::BUDGET_GOODBYE;
         end
         hsc_pkg::LS_CONNECTING: begin
            tick_active = 1'b1; has_budget = 1'b1; to_unreach = 1'b1;
            tick_kind = hsc_pkg::SK_HELLO; tick_gap = gaps.hello;
            tick_budget = hsc_pkg::BUDGET_HELLO;
         end
         hsc_pkg::LS_CONNECTED: begin
            tick_active = 1'b1; has_budget = 1'b1; to_unreach = 1'b1;
            tick_kind = hsc_pkg::SK_WAITING; tick_gap = gaps.wait_conn;
            tick_budget = hsc_pkg::BUDGET_WAIT;
         end
         hsc_pkg::LS_SYNCED: begin
            tick_active = 1'b1;
            if (!item.setup_in_sync) begin
               // setup drifted: fall into changed and act on it this tick
               base_state = hsc_pkg::LS_CHANGED; base_retry = '0;
               has_budget = 1'b1; to_unreach = 1'b1;
               tick_kind = hsc_pkg::SK_STATE; tick_gap = gaps.state;
               tick_budget = hsc_pkg::BUDGET_WAIT;
            end else begin
               tick_kind = hsc_pkg::SK_WAITING; tick_gap = gaps.wait_sync;
            end
         end
         hsc_pkg::LS_CHANGED: begin
            tick_active = 1'b1; has_budget = 1'b1; to_unreach = 1'b1;
            tick_kind = hsc_pkg::SK_STATE; tick_gap = gaps.state;
            tick_budget = hsc_pkg::BUDGET_WAIT;
         end
         hsc_pkg::LS_ASYNC: begin
            tick_active = 1'b1; has_budget = 1'b1; to_unreach = 1'b1;
            tick_kind = hsc_pkg::SK_RESYNC; tick_gap = gaps.state;
            tick_budget = hsc_pkg::BUDGET_WAIT;
         end
         hsc_pkg::LS_MAPINFO: begin
            tick_active = 1'b1; has_budget = 1'b1; to_unreach = 1'b1;
            tick_kind = hsc_pkg::SK_MAP; tick_gap = gaps.map;
            tick_budget = hsc_pkg::BUDGET_WAIT;
         end
         hsc_pkg::LS_BADMAP: begin
            tick_active = 1'b1; has_budget = 1'b1; to_unreach = 1'b1;
            tick_kind = hsc_pkg::SK_MISMATCH; tick_gap = gaps.map;
            tick_budget = hsc_pkg::BUDGET_WAIT;
         end
         hsc_pkg::LS_GOAHEAD: begin
            tick_active = 1'b1; has_budget = 1'b1; to_unreach = 1'b1;
            tick_kind = hsc_pkg::SK_CONFIG; tick_gap = gaps.start;
            tick_budget = hsc_pkg::BUDGET_CONFIG;
         end
         hsc_pkg::LS_STARTED: begin
            // out of budget finishes but keeps the state
            tick_active = 1'b1; has_budget = 1'b1;
            tick_kind = hsc_pkg::SK_GO; tick_gap = gaps.start;
            tick_budget = hsc_pkg::BUDGET_WAIT;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      nxt_link_state  = link_state;
      nxt_retry_count = retry_count;
      nxt_last_time   = last_time;
      nxt_last_kind   = last_kind;
      kind            = hsc_pkg::SK_NONE;
      keep            = 1'b1;
      ctl.burst       = 1'b0;
      case (item.op)
         hsc_pkg::OP_TICK: begin
            if (link_state == hsc_pkg::LS_DISCONNECTED) begin
               nxt_link_state = hsc_pkg::LS_USERCANCELED;
               kind           = hsc_pkg::SK_SEEYOU;
               keep           = 1'b0;
               ctl.burst      = 1'b1;
            end else if (tick_active) begin
               nxt_link_state  = base_state;
               nxt_retry_count = base_retry;
               if (has_budget && !(base_retry < tick_budget)) begin
                  keep = 1'b0;
                  if (to_unreach) begin
                     nxt_link_state = hsc_pkg::LS_UNREACHABLE;
                  end
               end else if (gap_ok) begin
                  kind          = tick_kind;
                  nxt_last_time = now_t;
                  if (tick_kind == last_kind) begin
                     nxt_retry_count = (base_retry == hsc_pkg::RETRY_MAX) ?
                                       base_retry : base_retry + 8'd1;
                  end else begin
                     nxt_retry_count = '0;
                     nxt_last_kind   = tick_kind;
                  end
               end
            end
         end
         hsc_pkg::OP_RX: begin
            if (item.from_server) begin
               case (item.rx_kind)
                  hsc_pkg::RX_QUIT: begin
                     nxt_link_state = hsc_pkg::LS_SERVERQUITS;
                     keep = 1'b0;
                  end
                  hsc_pkg::RX_AYT: begin
                     kind = hsc_pkg::SK_IAMHERE;
                  end
                  hsc_pkg::RX_GOODBYE: begin
                     if (link_state == hsc_pkg::LS_DETACHING) begin
                        nxt_link_state  = hsc_pkg::LS_DISCONNECTED;
                        nxt_retry_count = '0;
                     end
                  end
                  hsc_pkg::RX_ENGINE: begin
                     if (link_state == hsc_pkg::LS_CONNECTING) begin
                        nxt_link_state = hsc_pkg::LS_BADENGINE;
                     end
                     keep = 1'b0;
                  end
                  hsc_pkg::RX_PROTOCOL: begin
                     if (link_state == hsc_pkg::LS_CONNECTING) begin
                        nxt_link_state = hsc_pkg::LS_BADNETWORK;
                     end
                     keep = 1'b0;
                  end
                  hsc_pkg::RX_FULL: begin
                     if (link_state == hsc_pkg::LS_CONNECTING) begin
                        nxt_link_state = hsc_pkg::LS_NOFREESLOTS;
                     end
                     keep = 1'b0;
                  end
                  hsc_pkg::RX_WELCOME: begin
                     if (link_state == hsc_pkg::LS_CONNECTING) begin
                        nxt_link_state  = hsc_pkg::LS_CONNECTED;
                        nxt_retry_count = '0;
                     end
                  end
                  hsc_pkg::RX_MAP: begin
                     if (link_state == hsc_pkg::LS_CONNECTED) begin
                        if (!item.map_matches) begin
                           nxt_link_state = hsc_pkg::LS_BADMAP;
                        end else begin
                           nxt_link_state  = hsc_pkg::LS_MAPINFO;
                           nxt_retry_count = '0;
                        end
                     end
                  end
                  hsc_pkg::RX_STATE: begin
                     if (link_state == hsc_pkg::LS_MAPINFO) begin
                        nxt_link_state  = hsc_pkg::LS_SYNCED;
                        nxt_retry_count = '0;
                     end else if (link_state == hsc_pkg::LS_SYNCED ||
                                  link_state == hsc_pkg::LS_CHANGED) begin
                        nxt_link_state  = hsc_pkg::LS_ASYNC;
                        nxt_retry_count = '0;
                     end else if (link_state == hsc_pkg::LS_GOAHEAD) begin
                        nxt_link_state  = hsc_pkg::LS_STARTED;
                        nxt_retry_count = '0;
                     end
                  end
                  hsc_pkg::RX_CONFIG: begin
                     if (link_state == hsc_pkg::LS_SYNCED) begin
                        nxt_link_state  = hsc_pkg::LS_GOAHEAD;
                        nxt_retry_count = '0;
                     end
                  end
                  hsc_pkg::RX_RESYNC: begin
                     if (link_state == hsc_pkg::LS_ASYNC) begin
                        nxt_link_state  = hsc_pkg::LS_SYNCED;
                        nxt_retry_count = '0;
                     end
                  end
                  hsc_pkg::RX_GO: begin
                     keep = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         hsc_pkg::OP_DETACH: begin
            nxt_link_state  = hsc_pkg::LS_DETACHING;
            nxt_retry_count = '0;
         end
         hsc_pkg::OP_INIT: begin
            nxt_last_time   = now_t;
            nxt_link_state  = hsc_pkg::LS_CONNECTING;
            nxt_retry_count = '0;
            nxt_last_kind   = hsc_pkg::SK_NONE;
         end
         default: begin
         end
      endcase
      ctl.rsp.send_kind      = kind;
      ctl.rsp.keep_going     = keep;
      ctl.rsp.link_state_out = hsc_pkg::link_num(nxt_link_state);
   end

endmodule

// ----- hdl/hsc_out.sv -----
module hsc_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  hsc_pkg::step_ctl_type ctl,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output hsc_pkg::rsp_type      rsp,
   output logic                  rsp_last,
   output logic                  free
);

   logic                            vld_ff, vld_in;
   logic [hsc_pkg::BURST_CNT_W-1:0] rem_ff, rem_in;
   hsc_pkg::rsp_type                data_ff, data_in;

   assign rsp_valid = vld_ff;
   assign rsp       = data_ff;
   assign rsp_last  = (rem_ff == '0);
   assign free      = !vld_ff || (rsp_ready && rem_ff == '0);

   always_comb begin
      vld_in  = vld_ff;
      rem_in  = rem_ff;
      data_in = data_ff;
      if (vld_ff && rsp_ready) begin
         // repeat the same item until the burst count runs out
         if (rem_ff != '0) begin
            rem_in = rem_ff - 1'b1;
         end else begin
            vld_in = 1'b0;
         end
      end
      if (load) begin
         vld_in  = 1'b1;
         data_in = ctl.rsp;
         rem_in  = ctl.burst ? hsc_pkg::BURST_CNT_W'(hsc_pkg::FAREWELL_BURST - 1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         rem_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
